// File: rtl/gradient_map_pixel_core_macros.svh
// Assertion macros used by the gradient map back end.
`ifndef GRADIENT_MAP_PIXEL_CORE_MACROS_SVH
`define GRADIENT_MAP_PIXEL_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define GMP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define GMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gmp_pkg.sv
// Shared types and constants of the gradient map pixel core.
`default_nettype none
package gmp_pkg;

   // Request opcodes
   localparam logic OPC_LOAD  = 1'b0;
   localparam logic OPC_PIXEL = 1'b1;

   // Register indexes
   localparam logic CSR_REPLACE_MODE   = 1'b0;
   localparam logic CSR_SOURCE_CHANNEL = 1'b1;

   // Index source codes
   localparam logic [2:0] SRC_LUMA  = 3'd0;
   localparam logic [2:0] SRC_ALPHA = 3'd1;
   localparam logic [2:0] SRC_RED   = 3'd2;
   localparam logic [2:0] SRC_GREEN = 3'd3;
   localparam logic [2:0] SRC_BLUE  = 3'd4;

   // Fixed-point luma weights (sum is 1.0 in Q16)
   localparam logic [15:0] LUMA_R_COEF = 16'd19584;
   localparam logic [15:0] LUMA_G_COEF = 16'd38464;
   localparam logic [15:0] LUMA_B_COEF = 16'd7488;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0]  INDEX_MAX    = 8'd255;
   // ceil(2^23 / 255): exact x/255 for x below 65536
   localparam logic [15:0] DIV255_MUL   = 16'd32897;
   localparam int          DIV255_SHIFT = 23;
   // Reciprocal precision for c*255/alpha
   localparam int          RECIP_SHIFT  = 24;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // How the back end forms the result
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_PASS,
      KIND_ZERO,
      KIND_SCALE
   } kind_type;

   typedef struct packed {
      logic       replace_mode;
      logic [2:0] source_channel;
   } cfg_type;

   // Classified request travelling front to back
   typedef struct packed {
      kind_type    kind;
      logic        luma;
      logic        divide;
      logic [7:0]  v0;
      logic [7:0]  v1;
      logic [7:0]  v2;
      logic [7:0]  alpha;
      logic [7:0]  ld_index;
      logic [31:0] ld_data;
   } item_type;

endpackage
`default_nettype wire

// File: rtl/gmp_front.sv
// Front end: accepts requests and classifies them for the back end.
`default_nettype none
module gmp_front (
   input  wire             req_valid,
   input  wire             req_opcode,
   input  wire [7:0]       req_entry_index,
   input  wire [7:0]       req_entry_red,
   input  wire [7:0]       req_entry_green,
   input  wire [7:0]       req_entry_blue,
   input  wire [7:0]       req_entry_alpha,
   input  wire [7:0]       req_pixel_red,
   input  wire [7:0]       req_pixel_green,
   input  wire [7:0]       req_pixel_blue,
   input  wire [7:0]       req_pixel_alpha,
   input  gmp_pkg::cfg_type cfg,
   input  wire             queue_full,
   output logic            req_stall,
   output logic            push,
   output gmp_pkg::item_type push_item
);
   import gmp_pkg::*;

   logic [2:0] sel;
   logic [7:0] chan;
   logic       a_zero;
   logic       a_opaque;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Unused source codes fall back to luma
   assign sel = (cfg.source_channel > SRC_BLUE) ? SRC_LUMA : cfg.source_channel;

   always_comb begin
      unique case (sel)
         SRC_RED:   chan = req_pixel_red;
         SRC_GREEN: chan = req_pixel_green;
         SRC_BLUE:  chan = req_pixel_blue;
         default:   chan = req_pixel_alpha;
      endcase
   end

   assign a_zero   = (req_pixel_alpha == 8'd0);
   assign a_opaque = (req_pixel_alpha == ALPHA_OPAQUE);

   // Classification
   always_comb begin
      push_item          = '0;
      push_item.alpha    = req_pixel_alpha;
      push_item.ld_index = req_entry_index;
      push_item.ld_data  = {req_entry_alpha, req_entry_blue, req_entry_green, req_entry_red};
      if (req_opcode == OPC_LOAD) begin
         push_item.kind = KIND_LOAD;
      end else if (cfg.replace_mode) begin
         push_item.kind = KIND_PASS;
         priority if (sel == SRC_ALPHA) begin
            push_item.v0 = req_pixel_alpha;
         end else if (a_zero) begin
            push_item.v0 = 8'd0;
         end else if (sel == SRC_LUMA) begin
            push_item.luma = 1'b1;
         end else begin
            push_item.v0 = chan;
         end
      end else if (a_zero) begin
         push_item.kind = KIND_ZERO;
      end else begin
         push_item.kind   = a_opaque ? KIND_PASS : KIND_SCALE;
         push_item.divide = !a_opaque && (sel != SRC_ALPHA);
         push_item.luma   = (sel == SRC_LUMA);
         push_item.v0     = chan;
      end
      if (push_item.luma) begin
         push_item.v0 = req_pixel_red;
         push_item.v1 = req_pixel_green;
         push_item.v2 = req_pixel_blue;
      end
   end

endmodule
`default_nettype wire

// File: rtl/gmp_queue.sv
// Short request queue decoupling front and back end.
`default_nettype none
module gmp_queue #(
   parameter int DEPTH = gmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  gmp_pkg::item_type push_item,
   input  wire               pop,
   output gmp_pkg::item_type head,
   output logic              full,
   output logic              empty
);
   import gmp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: rtl/gmp_back.sv
// Back end: unpremultiply, luma index, color table and alpha scaling.
`default_nettype none
`include "gradient_map_pixel_core_macros.svh"
module gmp_back (
   input  wire               clock,
   input  wire               reset,
   input  gmp_pkg::item_type q_head,
   input  wire               q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue,
   output logic [7:0]        rsp_out_alpha
);
   import gmp_pkg::*;

   localparam int RW = RECIP_SHIFT + 1;

   // Reciprocal table ceil(2^24 / a), entry 0 unused
   logic [RW-1:0] recip_tab [256];
   for (genvar i = 0; i < 256; i++) begin : g_recip
      localparam longint RV = (i == 0) ? 0 :
         ((longint'(1) << RECIP_SHIFT) + i - 1) / ((i == 0) ? 1 : i);
      assign recip_tab[i] = RW'(RV);
   end

   logic adv;
   assign adv   = !rsp_valid || !rsp_stall;
   assign q_pop = adv && !q_empty;

   // Stage 1: reciprocal lookup and c*255
   logic          s1_valid_ff;
   item_type      s1_item_ff;
   logic [RW-1:0] s1_recip_ff;
   logic [15:0]   s1_n_ff [3];
   logic [7:0]    s1_v [3];
   assign s1_v[0] = q_head.v0;
   assign s1_v[1] = q_head.v1;
   assign s1_v[2] = q_head.v2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff  <= q_head;
         s1_recip_ff <= recip_tab[q_head.alpha];
         for (int k = 0; k < 3; k++) begin
            s1_n_ff[k] <= {s1_v[k], 8'd0} - {8'd0, s1_v[k]};
         end
      end
   end

   // Stage 2: quotient by reciprocal multiply
   logic        s2_valid_ff;
   item_type    s2_item_ff;
   logic [15:0] s2_c_ff [3];
   logic [15:0] s2_c_in [3];
   logic [7:0]  s1_raw [3];
   assign s1_raw[0] = s1_item_ff.v0;
   assign s1_raw[1] = s1_item_ff.v1;
   assign s1_raw[2] = s1_item_ff.v2;

   always_comb begin
      logic [RW+15:0] prod;
      for (int k = 0; k < 3; k++) begin
         prod = {{RW{1'b0}}, s1_n_ff[k]} * {16'd0, s1_recip_ff};
         s2_c_in[k] = s1_item_ff.divide ? prod[RECIP_SHIFT+15:RECIP_SHIFT]
                                        : {8'd0, s1_raw[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_item_ff <= s1_item_ff;
         s2_c_ff    <= s2_c_in;
      end
   end

   // Stage 3: luma products
   logic        s3_valid_ff;
   item_type    s3_item_ff;
   logic [31:0] s3_p_ff [3];
   logic [15:0] s3_c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_item_ff <= s2_item_ff;
         s3_c0_ff   <= s2_c_ff[0];
         s3_p_ff[0] <= s2_c_ff[0] * LUMA_R_COEF;
         s3_p_ff[1] <= s2_c_ff[1] * LUMA_G_COEF;
         s3_p_ff[2] <= s2_c_ff[2] * LUMA_B_COEF;
      end
   end

   // Stage 4: sum, clamp, table index
   logic        s4_valid_ff;
   kind_type    s4_kind_ff;
   logic [7:0]  s4_alpha_ff;
   logic [7:0]  s4_idx_ff;
   logic [31:0] s4_data_ff;
   logic [31:0] luma_sum;
   logic [15:0] idx_wide;
   logic [7:0]  s4_idx_in;

   assign luma_sum = s3_p_ff[0] + s3_p_ff[1] + s3_p_ff[2];
   assign idx_wide = s3_item_ff.luma ? luma_sum[31:16] : s3_c0_ff;

   always_comb begin
      if (s3_item_ff.kind == KIND_LOAD) begin
         s4_idx_in = s3_item_ff.ld_index;
      end else if (idx_wide > {8'd0, INDEX_MAX}) begin
         s4_idx_in = INDEX_MAX;
      end else begin
         s4_idx_in = idx_wide[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_kind_ff  <= s3_item_ff.kind;
         s4_alpha_ff <= s3_item_ff.alpha;
         s4_idx_ff   <= s4_idx_in;
         s4_data_ff  <= s3_item_ff.ld_data;
      end
   end

   // Stage 5: color table, one write and one registered read
   logic [31:0] color_table [256];
   logic        s5_valid_ff;
   kind_type    s5_kind_ff;
   logic [7:0]  s5_alpha_ff;
   logic [31:0] s5_entry_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s4_valid_ff && s4_kind_ff == KIND_LOAD) begin
            color_table[s4_idx_ff] <= s4_data_ff;
         end
         s5_entry_ff <= color_table[s4_idx_ff];
         s5_kind_ff  <= s4_kind_ff;
         s5_alpha_ff <= s4_alpha_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 6: entry times alpha
   logic        s6_valid_ff;
   kind_type    s6_kind_ff;
   logic [7:0]  s6_alpha_ff;
   logic [31:0] s6_entry_ff;
   logic [15:0] s6_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_kind_ff  <= s5_kind_ff;
         s6_alpha_ff <= s5_alpha_ff;
         s6_entry_ff <= s5_entry_ff;
         for (int k = 0; k < 3; k++) begin
            s6_prod_ff[k] <= s5_entry_ff[8*k +: 8] * s5_alpha_ff;
         end
      end
   end

   // Output register: divide by 255 and select result
   logic       rsp_valid_ff;
   logic [7:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic [7:0] scaled [3];
   logic [7:0] res_in [4];

   always_comb begin
      logic [31:0] q;
      for (int k = 0; k < 3; k++) begin
         q = s6_prod_ff[k] * DIV255_MUL;
         scaled[k] = q[DIV255_SHIFT+7:DIV255_SHIFT];
      end
   end

   always_comb begin
      unique case (s6_kind_ff)
         KIND_SCALE: begin
            res_in[0] = scaled[0];
            res_in[1] = scaled[1];
            res_in[2] = scaled[2];
            res_in[3] = s6_alpha_ff;
         end
         KIND_PASS: begin
            res_in[0] = s6_entry_ff[7:0];
            res_in[1] = s6_entry_ff[15:8];
            res_in[2] = s6_entry_ff[23:16];
            res_in[3] = s6_entry_ff[31:24];
         end
         default: begin
            res_in[0] = 8'd0;
            res_in[1] = 8'd0;
            res_in[2] = 8'd0;
            res_in[3] = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s6_valid_ff && (s6_kind_ff != KIND_LOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= res_in[0];
         rsp_green_ff <= res_in[1];
         rsp_blue_ff  <= res_in[2];
         rsp_alpha_ff <= res_in[3];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

   // Checks
   `GMP_ASSERT_NEXT(a_result_out, clock, reset, adv && s6_valid_ff && s6_kind_ff != KIND_LOAD, rsp_valid_ff, "pixel result lost")
   `GMP_ASSERT_NEXT(a_no_extra, clock, reset, adv && !(s6_valid_ff && s6_kind_ff != KIND_LOAD), !rsp_valid_ff, "spurious result")
   `GMP_ASSERT_NEVER(a_div_zero, clock, reset, s1_valid_ff && s1_item_ff.divide && s1_item_ff.alpha == 8'd0, "divide by zero alpha")

endmodule
`default_nettype wire

// File: rtl/gradient_map_pixel_core.sv
// Top level of the gradient map pixel core.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | opcode, entry fields, pixel fields
//  rsp     | out       | rsp_valid/rsp_stall | out_red/green/blue/alpha
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request per clock is accepted while the queue has room; loads give no result.
// A pixel result leaves the queue for the seven-register back end (reciprocal, quotient,
// luma, index, table, scale, output) whenever the back end advances.
// Synchronous active-high reset clears control only; the color table is not cleared.
// A stalled result freezes the back end; the queue then absorbs QUEUE_DEPTH requests
// before req_stall rises.
`default_nettype none
module gradient_map_pixel_core #(
   parameter int QUEUE_DEPTH = gmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire        req_opcode,
   input  wire [7:0]  req_entry_index,
   input  wire [7:0]  req_entry_red,
   input  wire [7:0]  req_entry_green,
   input  wire [7:0]  req_entry_blue,
   input  wire [7:0]  req_entry_alpha,
   input  wire [7:0]  req_pixel_red,
   input  wire [7:0]  req_pixel_green,
   input  wire [7:0]  req_pixel_blue,
   input  wire [7:0]  req_pixel_alpha,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_index,
   input  wire [2:0]  csr_wdata
);
   import gmp_pkg::*;

   cfg_type  cfg_ff;
   item_type push_item, q_head;
   logic     push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_REPLACE_MODE:   cfg_ff.replace_mode   <= csr_wdata[0];
            CSR_SOURCE_CHANNEL: cfg_ff.source_channel <= csr_wdata;
            default: ;
         endcase
      end
   end

   gmp_front u_front (
      .req_valid       (req_valid),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_entry_alpha (req_entry_alpha),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .req_pixel_alpha (req_pixel_alpha),
      .cfg             (cfg_ff),
      .queue_full      (q_full),
      .req_stall       (req_stall),
      .push            (push),
      .push_item       (push_item)
   );

   gmp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   gmp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the gradient map pixel core.
`default_nettype none
module tb;
   import gmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_opcode;
   logic [7:0] req_entry_index;
   logic [7:0] req_entry_red;
   logic [7:0] req_entry_green;
   logic [7:0] req_entry_blue;
   logic [7:0] req_entry_alpha;
   logic [7:0] req_pixel_red;
   logic [7:0] req_pixel_green;
   logic [7:0] req_pixel_blue;
   logic [7:0] req_pixel_alpha;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [2:0] csr_wdata;

   // Shadow of the block's state and registers
   logic [31:0] color_table [256];
   bit          entry_written [256];
   logic        replace_mode_q;
   logic [2:0]  source_channel_q;

   pixel_type   expected_pixels [$];
   int          mismatch_count;
   int          pixels_checked;
   int          loads_sent;
   int          idle_cycles;
   int          hold_cycles;
   int          stall_left;
   bit          quiet;

   gradient_map_pixel_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_entry_index(req_entry_index), .req_entry_red(req_entry_red),
      .req_entry_green(req_entry_green), .req_entry_blue(req_entry_blue),
      .req_entry_alpha(req_entry_alpha), .req_pixel_red(req_pixel_red),
      .req_pixel_green(req_pixel_green), .req_pixel_blue(req_pixel_blue),
      .req_pixel_alpha(req_pixel_alpha),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green), .rsp_out_blue(rsp_out_blue),
      .rsp_out_alpha(rsp_out_alpha),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] saturate_index(longint unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] luma_index(longint unsigned r, longint unsigned g,
                                             longint unsigned b);
      return saturate_index((r * LUMA_R_COEF + g * LUMA_G_COEF + b * LUMA_B_COEF) >> 16);
   endfunction

   // Table index a pixel selects; reads is cleared when no entry is used
   function automatic logic [7:0] table_index(input logic [7:0] r, g, b, a,
                                              output bit reads);
      logic [2:0] sel;
      logic [7:0] chan;
      sel   = (source_channel_q > SRC_BLUE) ? SRC_LUMA : source_channel_q;
      chan  = (sel == SRC_RED) ? r : ((sel == SRC_GREEN) ? g : b);
      reads = 1'b1;
      if (replace_mode_q) begin
         if (sel == SRC_ALPHA) return a;
         if (a == 0) return 8'd0;
         if (sel == SRC_LUMA) return luma_index(r, g, b);
         return chan;
      end
      if (a == 0) begin
         reads = 1'b0;
         return 8'd0;
      end
      if (sel == SRC_ALPHA) return a;
      if (a == ALPHA_OPAQUE) return (sel == SRC_LUMA) ? luma_index(r, g, b) : chan;
      // partial alpha: unpremultiply first
      if (sel == SRC_LUMA)
         return luma_index(longint'(r) * 255 / a, longint'(g) * 255 / a,
                           longint'(b) * 255 / a);
      return saturate_index(longint'(chan) * 255 / a);
   endfunction

   function automatic pixel_type map_pixel(logic [7:0] r, g, b, a);
      pixel_type   p;
      logic [31:0] e;
      logic [7:0]  idx;
      bit          reads;
      idx = table_index(r, g, b, a, reads);
      e   = color_table[idx];
      if (!reads)
         p = '0;
      else if (!replace_mode_q && a != ALPHA_OPAQUE) begin
         p.red   = 8'(int'(e[7:0]) * a / 255);
         p.green = 8'(int'(e[15:8]) * a / 255);
         p.blue  = 8'(int'(e[23:16]) * a / 255);
         p.alpha = a;
      end else begin
         p.red   = e[7:0];
         p.green = e[15:8];
         p.blue  = e[23:16];
         p.alpha = e[31:24];
      end
      return p;
   endfunction

   // Drive one request and wait for its acceptance, then maybe leave a gap
   task automatic send_request(logic op, logic [7:0] idx, logic [31:0] entry,
                               logic [7:0] r, g, b, a);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_entry_red   <= entry[7:0];
      req_entry_green <= entry[15:8];
      req_entry_blue  <= entry[23:16];
      req_entry_alpha <= entry[31:24];
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      req_pixel_alpha <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OPC_LOAD) begin
         color_table[idx]   = entry;
         entry_written[idx] = 1'b1;
         loads_sent++;
      end else
         expected_pixels.push_back(map_pixel(r, g, b, a));
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_load(logic [7:0] idx, logic [31:0] entry);
      send_request(OPC_LOAD, idx, entry, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   // Loads the selected entry first if it was never written
   task automatic send_pixel(logic [7:0] r, g, b, a);
      logic [7:0] idx;
      bit         reads;
      idx = table_index(r, g, b, a, reads);
      if (reads && !entry_written[idx]) send_load(idx, $urandom);
      send_request(OPC_PIXEL, 8'($urandom), $urandom, r, g, b, a);
   endtask

   task automatic send_random_item();
      logic [7:0] a;
      int         kind;
      if ($urandom_range(0, 4) == 0) begin
         send_load(8'($urandom), $urandom);
         return;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) a = 8'd0;
      else if (kind <= 2) a = ALPHA_OPAQUE;
      else a = 8'($urandom_range(1, 254));
      // well-formed premultiplied colour most of the time
      if (kind >= 3 && kind <= 7)
         send_pixel(8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                    8'($urandom_range(0, a)), a);
      else
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), a);
   endtask

   // Stop requesting, wait out all results and the loads still in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [2:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_REPLACE_MODE) replace_mode_q = value[0];
      else source_channel_q = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(logic mode, logic [2:0] chan);
      settle();
      write_reg(CSR_REPLACE_MODE, {2'b00, mode});
      write_reg(CSR_SOURCE_CHANNEL, chan);
   endtask

   // Extremes, transparent/opaque/partial alpha and index saturation
   task automatic test_directed();
      logic [2:0] chans [4] = '{SRC_LUMA, SRC_LUMA, SRC_RED, SRC_ALPHA};
      for (int i = 0; i < 4; i++) begin
         set_mode(i[0], chans[i]);
         if (i == 0) begin
            send_load(8'd0, 32'h0000_0000);
            send_load(8'd255, 32'hFFFF_FFFF);
         end
         send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
         send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
         send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
         send_pixel(8'd60, 8'd120, 8'd30, 8'd128);
         send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
         send_pixel(8'd200, 8'd10, 8'd10, 8'd100);
      end
   endtask

   // Random traffic across register settings, unused channel codes included
   task automatic test_random_sweep();
      logic       modes [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      logic [2:0] chans [8] = '{SRC_ALPHA, SRC_GREEN, SRC_BLUE, 3'd7, 3'd5, SRC_RED,
                                3'd6, SRC_BLUE};
      for (int s = 0; s < 8; s++) begin
         set_mode(modes[s], chans[s]);
         repeat (60) send_random_item();
      end
   endtask

   // Receiver holds off long enough to fill the block and stall requests
   task automatic test_backpressure();
      set_mode(1'b0, SRC_LUMA);
      hold_cycles = 200;
      repeat (40) send_random_item();
   endtask

   // Sender waits for every result mid-stream
   task automatic test_drain_pause();
      repeat (15) send_random_item();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (15) send_random_item();
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_full_rate();
      quiet = 1'b1;
      repeat (60) send_random_item();
   endtask

   // Receiver stall: long hold, random bursts, none at the end
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= 1'b0;
   end

   // Result checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result %h %h %h %h", rsp_out_red,
                        rsp_out_green, rsp_out_blue, rsp_out_alpha);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                want.blue !== rsp_out_blue || want.alpha !== rsp_out_alpha) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: rgba expected %h %h %h %h got %h %h %h %h",
                           want.red, want.green, want.blue, want.alpha, rsp_out_red,
                           rsp_out_green, rsp_out_blue, rsp_out_alpha);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OPC_LOAD; req_entry_index = '0;
      req_entry_red = '0; req_entry_green = '0; req_entry_blue = '0;
      req_entry_alpha = '0; req_pixel_red = '0; req_pixel_green = '0;
      req_pixel_blue = '0; req_pixel_alpha = '0;
      rsp_stall = 1'b0; csr_valid = 1'b0; csr_index = CSR_REPLACE_MODE; csr_wdata = '0;
      replace_mode_q = 1'b0; source_channel_q = SRC_LUMA;
      mismatch_count = 0; pixels_checked = 0; loads_sent = 0;
      idle_cycles = 0; hold_cycles = 0; stall_left = 0; quiet = 1'b0;
      foreach (entry_written[i]) entry_written[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_sweep();
      test_backpressure();
      test_drain_pause();
      test_full_rate();
      settle();

      $display("Covered %0d pixel results and %0d table loads over both modes and",
               pixels_checked, loads_sent);
      $display("all index sources, with stalls, a long hold-off and a drain pause.");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/gmp_pkg.sv
rtl/gmp_front.sv
rtl/gmp_queue.sv
rtl/gmp_back.sv
rtl/gradient_map_pixel_core.sv
bench/tb.sv
